// ----- hdl/fbpa_pkg.sv -----
// Package for the fixed block pool allocator: widths, codes, controller states.
// No dependencies.
package fbpa_pkg;
   localparam int NUM_FRAMES_DEF = 16;
   localparam int MAX_SLOTS_DEF  = 256;
   localparam int CFG_W          = 9;
   localparam logic [CFG_W-1:0] SPC_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_SHRINK = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MEMB_UNASSIGNED = 2'd0,
      MEMB_USABLE     = 2'd1,
      MEMB_FULL       = 2'd2,
      MEMB_SPARE      = 2'd3
   } memb_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_LINK,
      ST_EXEC,
      ST_SHRINK,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request
      logic assign_f;  // assign lowest free frame
      logic init_step; // write one link of the new frame
      logic rd_link;   // read slot link memory
      logic exec;      // perform alloc / free update
      logic shrink;    // release front frame
      logic load_rsp;  // load response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       is_alloc;
      logic       is_shrink;
      logic       need_assign;
      logic       no_frame;
      logic       init_done;
      logic       shrink_more;
   } sts_type;
endpackage

// ----- hdl/fbpa_ctrl.sv -----
// Controller state machine for the pool allocator.
// Depends on fbpa_pkg.
module fbpa_ctrl
   import fbpa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   input  sts_type sts,
   output cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_INIT;
         ST_INIT: begin
            if (sts.is_shrink)                       state_in = ST_SHRINK;
            else if (sts.is_alloc && sts.need_assign) begin
               if (sts.no_frame) state_in = ST_RESP;
               else              state_in = ST_LINK;
            end else                                   state_in = ST_EXEC;
         end
         ST_LINK:   if (sts.init_done) state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_RESP;
         ST_SHRINK: if (!sts.shrink_more) state_in = ST_RESP;
         ST_RESP:   if (rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_INIT: begin
            cmd.assign_f = sts.is_alloc && sts.need_assign && !sts.no_frame;
            cmd.rd_link  = !(sts.is_alloc && sts.need_assign);
         end
         ST_LINK: begin
            cmd.init_step = 1'b1;
            cmd.rd_link   = sts.init_done;
         end
         ST_EXEC:   cmd.exec = 1'b1;
         ST_SHRINK: cmd.shrink = sts.shrink_more;
         ST_RESP:   rsp_tvalid = 1'b1;
         default: ;
      endcase
      cmd.load_rsp = (state_ff == ST_EXEC) || (state_ff == ST_SHRINK && !sts.shrink_more) ||
                     (state_ff == ST_INIT && sts.is_alloc && sts.need_assign && sts.no_frame);
   end
endmodule

// ----- hdl/fbpa_datapath.sv -----
// Datapath of the pool allocator: frame tables, usable list, slot link memory.
// Depends on fbpa_pkg.
module fbpa_datapath
   import fbpa_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic [13:0]      req_tdata,
   input  cmd_type          cmd,
   output sts_type          sts,
   output logic [17:0]      rsp_tdata
);
   localparam int FW = $clog2(NUM_FRAMES + 1);  // frame index plus empty marker
   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam logic [FW-1:0] NIL = FW'(NUM_FRAMES);

   logic [CW-1:0]  spc_ff;
   op_type         op_ff;
   logic [3:0]     fc_ff;
   logic [7:0]     fs_ff;
   memb_type       memb_ff  [NUM_FRAMES];
   logic [CW-1:0]  cnt_ff   [NUM_FRAMES];
   logic [SW-1:0]  head_ff  [NUM_FRAMES];
   logic [FW-1:0]  prev_ff  [NUM_FRAMES];
   logic [FW-1:0]  next_ff  [NUM_FRAMES];
   logic [FW-1:0]  front_ff, back_ff;
   logic [SW-1:0]  link_mem [NUM_FRAMES*MAX_SLOTS];
   logic [SW-1:0]  link_rd_ff;
   logic [CW-1:0]  init_ff;
   logic [IW-1:0]  newf_ff;
   logic [4:0]     rel_ff;
   logic [17:0]    rsp_ff;

   // config clamp
   logic [CFG_W-1:0] cfg_v;
   always_comb begin
      cfg_v = csr_wdata;
      if (cfg_v == '0) cfg_v = CFG_W'(1);
      if (32'(cfg_v) > MAX_SLOTS) cfg_v = CFG_W'(MAX_SLOTS);
   end

   // lowest unassigned frame
   logic          found;
   logic [IW-1:0] low_f;
   always_comb begin
      found = 1'b0;
      low_f = '0;
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if (memb_ff[i] == MEMB_UNASSIGNED) begin
            found = 1'b1;
            low_f = IW'(i);
         end
      end
   end

   // addressing for link memory
   logic          fc_ok;
   logic [IW-1:0] fc_i, back_i, front_i;
   assign fc_ok   = 32'(fc_ff) < NUM_FRAMES;
   assign fc_i    = IW'(fc_ff);
   assign back_i  = IW'(back_ff);
   assign front_i = IW'(front_ff);
   logic [SW-1:0] fs_s;
   assign fs_s = SW'(fs_ff);

   logic [$clog2(NUM_FRAMES*MAX_SLOTS)-1:0] rd_addr, wr_addr;
   logic [SW-1:0] wr_data;
   logic          wr_en;
   logic [SW-1:0] init_s;
   logic [CW-1:0] init_nx;
   assign init_s  = SW'(init_ff);
   assign init_nx = init_ff + CW'(1);
   logic          alloc_f;
   assign alloc_f = (op_ff == OP_ALLOC);
   logic [IW-1:0] tgt_f;
   assign tgt_f = alloc_f ? ((back_ff == NIL) ? newf_ff : back_i) : fc_i;

   // free eligibility
   logic free_ok;
   assign free_ok = (op_ff == OP_FREE) && fc_ok && memb_ff[fc_i] != MEMB_UNASSIGNED &&
                    32'(fs_ff) < 32'(spc_ff) && cnt_ff[fc_i] < spc_ff;

   always_comb begin
      rd_addr = '0;
      rd_addr = ($bits(rd_addr))'(tgt_f) * ($bits(rd_addr))'(MAX_SLOTS) +
                ($bits(rd_addr))'(head_ff[tgt_f]);
      wr_en   = 1'b0;
      wr_data = '0;
      wr_addr = ($bits(wr_addr))'(newf_ff) * ($bits(wr_addr))'(MAX_SLOTS) +
                ($bits(wr_addr))'(init_s);
      if (cmd.init_step) begin
         wr_en   = 1'b1;
         wr_data = (init_nx < spc_ff) ? SW'(init_nx) : '0;
      end else if (cmd.exec && !alloc_f && free_ok) begin
         wr_en   = 1'b1;
         wr_data = head_ff[fc_i];
         wr_addr = ($bits(wr_addr))'(fc_i) * ($bits(wr_addr))'(MAX_SLOTS) +
                   ($bits(wr_addr))'(fs_s);
      end
   end

   // a one-slot frame writes and reads slot 0 in the same cycle: pass the write through
   always_ff @(posedge clock) begin
      if (wr_en) link_mem[wr_addr] <= wr_data;
      if (cmd.rd_link) link_rd_ff <= (wr_en && wr_addr == rd_addr) ? wr_data : link_mem[rd_addr];
   end

   assign sts.is_alloc    = alloc_f;
   assign sts.is_shrink   = (op_ff == OP_SHRINK);
   assign sts.need_assign = (back_ff == NIL);
   assign sts.no_frame    = !found;
   assign sts.init_done   = (init_nx >= spc_ff);
   assign sts.shrink_more = (front_ff != NIL) && (cnt_ff[front_i] >= spc_ff);

   // list helpers computed per operation in the sequential block
   always_ff @(posedge clock) begin
      logic [FW-1:0] p, n;
      logic [CW-1:0] c;
      logic [IW-1:0] f;
      logic [FW-1:0] fr, bk;
      if (reset) begin
         spc_ff   <= CW'(SPC_RESET > CFG_W'(MAX_SLOTS) ? CFG_W'(MAX_SLOTS) : SPC_RESET);
         front_ff <= NIL;
         back_ff  <= NIL;
         for (int i = 0; i < NUM_FRAMES; i++) begin
            memb_ff[i] <= MEMB_UNASSIGNED;
            cnt_ff[i]  <= '0;
         end
         rsp_ff <= '0;
      end else begin
         if (csr_we) spc_ff <= CW'(cfg_v);
         if (cmd.capture) begin
            op_ff  <= op_type'(req_tdata[1:0]);
            fc_ff  <= req_tdata[5:2];
            fs_ff  <= req_tdata[13:6];
            rel_ff <= '0;
         end
         if (cmd.assign_f) begin
            newf_ff <= low_f;
            init_ff <= '0;
            head_ff[low_f] <= '0;
            cnt_ff[low_f]  <= spc_ff;
            memb_ff[low_f] <= MEMB_USABLE;
            // usable list is empty here: push front makes it the only node
            prev_ff[low_f] <= NIL;
            next_ff[low_f] <= NIL;
            front_ff <= FW'(low_f);
            back_ff  <= FW'(low_f);
         end
         if (cmd.init_step) init_ff <= init_nx;
         if (cmd.exec) begin
            fr = front_ff;
            bk = back_ff;
            if (alloc_f) begin
               f = back_i;
               head_ff[f] <= link_rd_ff;
               c = (cnt_ff[f] > '0) ? cnt_ff[f] - CW'(1) : cnt_ff[f];
               cnt_ff[f] <= c;
               if (c == '0) begin
                  p = prev_ff[f];
                  if (p == NIL) front_ff <= NIL; else next_ff[IW'(p)] <= NIL;
                  back_ff <= p;
                  memb_ff[f] <= MEMB_FULL;
               end
               rsp_ff <= {5'd0, 8'(head_ff[f]), 4'(f), 1'b0};
            end else begin
               rsp_ff <= '0;
               if (free_ok) begin
                  f = fc_i;
                  head_ff[f] <= fs_s;
                  c = cnt_ff[f] + CW'(1);
                  cnt_ff[f] <= c;
                  if (c == CW'(1)) begin
                     // frame was full, so not on the list: push back
                     memb_ff[f] <= MEMB_USABLE;
                     prev_ff[f] <= bk;
                     next_ff[f] <= NIL;
                     if (bk == NIL) front_ff <= FW'(f); else next_ff[IW'(bk)] <= FW'(f);
                     back_ff <= FW'(f);
                  end else if (c >= spc_ff) begin
                     p = prev_ff[f];
                     n = next_ff[f];
                     if (p != NIL && cnt_ff[IW'(p)] != spc_ff) begin
                        // unlink (p is not NIL) then push to front
                        next_ff[IW'(p)] <= n;
                        if (n == NIL) back_ff <= p; else prev_ff[IW'(n)] <= p;
                        prev_ff[f] <= NIL;
                        next_ff[f] <= fr;
                        prev_ff[IW'(fr)] <= FW'(f);
                        front_ff <= FW'(f);
                     end
                  end
               end
            end
         end
         if (cmd.shrink) begin
            f = front_i;
            n = next_ff[f];
            front_ff <= n;
            if (n == NIL) back_ff <= NIL; else prev_ff[IW'(n)] <= NIL;
            memb_ff[f] <= MEMB_UNASSIGNED;
            cnt_ff[f]  <= '0;
            rel_ff     <= rel_ff + 5'd1;
         end
         if (cmd.load_rsp && !cmd.exec) begin
            if (op_ff == OP_SHRINK) rsp_ff <= {rel_ff, 13'd0};
            else                    rsp_ff <= 18'd1;
         end
      end
   end

   assign rsp_tdata = rsp_ff;
endmodule

// ----- hdl/fixed_block_pool_allocator_top.sv -----
// Top level of the fixed block pool allocator: controller plus datapath.
// Depends on fbpa_pkg, fbpa_ctrl, fbpa_datapath.
//
// One request at a time. Allocate from a usable frame, free and an unknown
// operation pass through capture, link read, update and respond. An
// allocate that finds no frame left skips the update. An allocate that
// must assign a fresh frame first builds its free list in the link memory,
// one write a cycle for each slot of the frame (slots_per_chunk). Shrink
// releases one front frame per step, then makes one final check before it
// responds. The response is held until taken; the next request is accepted
// the cycle after.
module fixed_block_pool_allocator_top
   import fbpa_pkg::*;
#(
   parameter int NUM_FRAMES = NUM_FRAMES_DEF,
   parameter int MAX_SLOTS  = MAX_SLOTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // operation[1:0] free_chunk[5:2] free_slot[13:6]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata    // status[0] alloc_chunk[4:1] alloc_slot[12:5]
                                         // released_count[17:13]
);
   cmd_type     cmd;
   sts_type     sts;
   logic [17:0] rsp_d;

   fbpa_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd
   );

   fbpa_datapath #(.NUM_FRAMES(NUM_FRAMES), .MAX_SLOTS(MAX_SLOTS)) u_dp (
      .clock, .reset, .csr_we, .csr_wdata,
      .req_tdata(req_tdata[13:0]), .cmd, .sts, .rsp_tdata(rsp_d)
   );

   assign rsp_tdata = {6'd0, rsp_d};
endmodule

// ----- verif/tb_fixed_block_pool_allocator_top.sv -----
// Self-checking testbench for fixed_block_pool_allocator_top: a scoreboard class
// predicts each response, plain tasks drive requests, config writes and stalls.
// Depends on fbpa_pkg and the allocator RTL.
module tb_fixed_block_pool_allocator_top
   import fbpa_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NF  = NUM_FRAMES_DEF;
   localparam int MS  = MAX_SLOTS_DEF;
   localparam int NIL = NUM_FRAMES_DEF;   // empty marker of the usable list

   // response fields, highest bit first in rsp_tdata
   typedef struct packed {
      logic [4:0] released_count;
      logic [7:0] alloc_slot;
      logic [3:0] alloc_chunk;
      logic       status;
   } pool_rsp_type;

   // Shadow of the allocator: frame lists, slot links and the slots handed out.
   class pool_scoreboard;
      int           spc;
      memb_type     memb [NF];
      int           free_cnt [NF];
      int           free_head [NF];
      int           slot_link [NF][MS];
      int           prv [NF];
      int           nxt [NF];
      int           front, back;
      pool_rsp_type expected_rsp [$];
      int           live_blocks [$];   // chunk*MS + slot of each block handed out
      int           errors;

      function void clear();
         spc = MS;
         front = NIL;
         back = NIL;
         errors = 0;
         foreach (memb[f]) begin
            memb[f] = MEMB_UNASSIGNED;
            free_cnt[f] = 0;
            free_head[f] = 0;
            prv[f] = 0;
            nxt[f] = 0;
            for (int s = 0; s < MS; s++) slot_link[f][s] = 0;
         end
      endfunction

      function void write_spc(int v);
         v = v & 9'h1FF;
         if (v == 0) v = 1;
         if (v > MS) v = MS;
         spc = v;
      endfunction

      function void unlink(int f);
         int p, n;
         p = prv[f];
         n = nxt[f];
         if (p == NIL) front = n; else nxt[p] = n;
         if (n == NIL) back = p; else prv[n] = p;
      endfunction

      function void push_back(int f);
         prv[f] = back;
         nxt[f] = NIL;
         if (back == NIL) front = f; else nxt[back] = f;
         back = f;
      endfunction

      function void push_front(int f);
         nxt[f] = front;
         prv[f] = NIL;
         if (front == NIL) back = f; else prv[front] = f;
         front = f;
      endfunction

      // takes the lowest unassigned frame and queues its slots in order
      function bit take_frame();
         int f;
         for (f = 0; f < NF; f++)
            if (memb[f] == MEMB_UNASSIGNED) break;
         if (f >= NF) return 0;
         for (int i = 0; i < spc; i++) slot_link[f][i] = (i + 1 < spc) ? i + 1 : 0;
         free_head[f] = 0;
         free_cnt[f] = spc;
         memb[f] = MEMB_USABLE;
         push_front(f);
         return 1;
      endfunction

      function void note_request(op_type op, int fc, int fs);
         pool_rsp_type r;
         int f, s, p;
         r = '0;
         if (op == OP_ALLOC) begin
            if (back == NIL && !take_frame()) begin
               r.status = 1'b1;
            end else begin
               f = back;
               s = free_head[f] % MS;
               free_head[f] = slot_link[f][s];
               if (free_cnt[f] > 0) free_cnt[f]--;
               if (free_cnt[f] == 0) begin
                  unlink(f);
                  memb[f] = MEMB_FULL;
               end
               r.alloc_chunk = 4'(f);
               r.alloc_slot = 8'(s);
               live_blocks.push_back(f * MS + s);
            end
         end else if (op == OP_FREE) begin
            if (fc < NF && memb[fc] != MEMB_UNASSIGNED && fs < spc && free_cnt[fc] < spc) begin
               slot_link[fc][fs] = free_head[fc];
               free_head[fc] = fs;
               free_cnt[fc]++;
               if (free_cnt[fc] == 1) begin
                  if (memb[fc] == MEMB_USABLE) unlink(fc);
                  memb[fc] = MEMB_USABLE;
                  push_back(fc);
               end else if (free_cnt[fc] >= spc) begin
                  p = prv[fc];
                  if (p != NIL && free_cnt[p] != spc) begin
                     unlink(fc);
                     push_front(fc);
                  end
               end
            end
         end else if (op == OP_SHRINK) begin
            while (front != NIL && free_cnt[front] >= spc) begin
               f = front;
               unlink(f);
               memb[f] = MEMB_UNASSIGNED;
               free_cnt[f] = 0;
               r.released_count++;
            end
         end
         expected_rsp.push_back(r);
      endfunction

      function void check_response(pool_rsp_type got);
         pool_rsp_type exp_r;
         if (expected_rsp.size() == 0) begin
            $error("response with none expected: %h", got);
            errors++;
            return;
         end
         exp_r = expected_rsp.pop_front();
         if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            errors++;
         end
         if (got.alloc_chunk !== exp_r.alloc_chunk) begin
            $error("alloc_chunk: expected %0d, got %0d", exp_r.alloc_chunk, got.alloc_chunk);
            errors++;
         end
         if (got.alloc_slot !== exp_r.alloc_slot) begin
            $error("alloc_slot: expected %0d, got %0d", exp_r.alloc_slot, got.alloc_slot);
            errors++;
         end
         if (got.released_count !== exp_r.released_count) begin
            $error("released_count: expected %0d, got %0d",
                   exp_r.released_count, got.released_count);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic [CFG_W-1:0] csr_wdata;
   logic             req_tvalid;
   logic             req_tready;
   logic [15:0]      req_tdata;   // operation[1:0] free_chunk[5:2] free_slot[13:6]
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [23:0]      rsp_tdata;   // status[0] alloc_chunk[4:1] alloc_slot[12:5]
                                  // released_count[17:13]

   pool_scoreboard pool_sb;
   bit             no_idle;       // stretch with no gaps on either side

   fixed_block_pool_allocator_top u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous limit: covers building the free list of fresh 256-slot frames, plus stalls.
   initial begin
      #30ms;
      $display("Test completed with failures");
      $finish;
   end

   // One request: optional gap, then hold valid until the block takes it.
   // Valid is left high so back-to-back requests never drop it.
   // Ready only moves at rising edges, so it is looked at mid-cycle.
   task automatic send_request(op_type op, int fc, int fs);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, fs[7:0], fc[3:0], op};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      pool_sb.note_request(op, fc, fs);
   endtask

   // Drain everything outstanding, then write the register while idle.
   task automatic drain_and_config(int v);
      @(posedge clock);
      req_tvalid <= 1'b0;
      while (pool_sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CFG_W'(v);
      @(posedge clock);
      csr_we    <= 1'b0;
      pool_sb.write_spc(v);
   endtask

   // Free a block that is actually out, if any; otherwise allocate.
   task automatic free_live();
      int idx, blk;
      if (pool_sb.live_blocks.size() == 0) begin
         send_request(OP_ALLOC, 0, 0);
      end else begin
         idx = $urandom_range(0, pool_sb.live_blocks.size() - 1);
         blk = pool_sb.live_blocks[idx];
         pool_sb.live_blocks.delete(idx);
         send_request(OP_FREE, blk / MS, blk % MS);
      end
   endtask

   // Mostly well-formed alloc/free traffic; some noise frees, shrinks, op 3.
   task automatic random_phase(int n);
      int pick;
      for (int i = 0; i < n; i++) begin
         if (i % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 44) send_request(OP_ALLOC, $urandom_range(0, 15), $urandom_range(0, 255));
         else if (pick < 80) free_live();
         else if (pick < 88)
            send_request(OP_FREE, $urandom_range(0, 15), $urandom_range(0, 255));
         else if (pick < 96) send_request(OP_SHRINK, $urandom_range(0, 15), $urandom_range(0, 255));
         else send_request(OP_NONE, $urandom_range(0, 15), $urandom_range(0, 255));
      end
      no_idle = 0;
   endtask

   // Response side: random stall per response, checked at the handshake edge.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(negedge clock); while (!rsp_tvalid);
         @(posedge clock);
         pool_sb.check_response(pool_rsp_type'(rsp_tdata[17:0]));
      end
   end

   initial begin
      int wait_cnt;
      pool_sb = new();
      pool_sb.clear();
      no_idle    = 0;
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset size 256: fresh frame, frees back to fully free, shrink.
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_FREE, 15, 255);     // unassigned frame: ignored
      send_request(OP_FREE, 0, 1);
      send_request(OP_FREE, 0, 0);        // frame fully free again
      send_request(OP_FREE, 0, 7);        // already fully free: ignored
      send_request(OP_SHRINK, 0, 0);      // releases frame 0
      send_request(OP_SHRINK, 0, 0);      // nothing left
      send_request(OP_NONE, 15, 255);
      pool_sb.live_blocks.delete();

      // Directed, two slots per frame: out of frames, slot beyond size, double free.
      drain_and_config(2);
      repeat (33) send_request(OP_ALLOC, 0, 0);   // 16 frames full, then out of memory
      send_request(OP_FREE, 3, 2);        // slot at size: ignored
      send_request(OP_FREE, 3, 0);
      send_request(OP_FREE, 3, 0);        // double free accepted
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_ALLOC, 0, 0);
      pool_sb.live_blocks.delete();
      send_request(OP_SHRINK, 0, 0);

      // Random phases over several sizes; each write waits for an idle block,
      // which also gives the pause-until-drained the sender must do.
      random_phase(220);
      drain_and_config(1);
      random_phase(220);
      drain_and_config(0);                // taken as one
      random_phase(160);
      drain_and_config(5);
      random_phase(240);
      drain_and_config(256);
      random_phase(220);
      drain_and_config(511);              // clamps to 256
      random_phase(160);
      drain_and_config(17);
      random_phase(220);
      drain_and_config(3);
      random_phase(150);

      @(posedge clock);
      req_tvalid <= 1'b0;
      wait_cnt = 0;
      while (pool_sb.expected_rsp.size() != 0 && wait_cnt < 100000) begin
         @(posedge clock);
         wait_cnt++;
      end
      repeat (300) @(posedge clock);
      if (pool_sb.errors == 0 && pool_sb.expected_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
